// File: design/c8x_pkg.sv
// shared types and constants for the chip-8 execute unit
// no dependencies
`timescale 1ns / 1ps
package c8x_pkg;
  localparam logic [2:0] ACT_INC   = 3'd0;
  localparam logic [2:0] ACT_NOINC = 3'd1;
  localparam logic [2:0] ACT_SKIP  = 3'd2;
  localparam logic [2:0] ACT_QUIT  = 3'd3;
  localparam logic [2:0] ACT_ERR   = 3'd4;

  localparam logic [2:0] DISP_NONE  = 3'd0;
  localparam logic [2:0] DISP_CLEAR = 3'd1;
  localparam logic [2:0] DISP_SDOWN = 3'd2;
  localparam logic [2:0] DISP_SRIGHT = 3'd3;
  localparam logic [2:0] DISP_SLEFT = 3'd4;
  localparam logic [2:0] DISP_DRAW  = 3'd5;

  localparam logic [1:0] REQ_EXEC  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // shared alu operations
  localparam logic [3:0] ALU_PASS_B = 4'd0;
  localparam logic [3:0] ALU_OR     = 4'd1;
  localparam logic [3:0] ALU_AND    = 4'd2;
  localparam logic [3:0] ALU_XOR    = 4'd3;
  localparam logic [3:0] ALU_ADD    = 4'd4;
  localparam logic [3:0] ALU_SUB    = 4'd5;
  localparam logic [3:0] ALU_SHR    = 4'd6;
  localparam logic [3:0] ALU_SHL    = 4'd7;

  typedef struct packed {
    logic [3:0] op;
    logic [7:0] a;
    logic [7:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [7:0] y;
    logic       flag;
    logic       eq;
  } alu_rsp_t;
endpackage

// File: design/c8x_ram.sv
// generic single port ram with registered read
// no dependencies
`timescale 1ns / 1ps
module c8x_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// File: design/c8x_alu.sv
// shared 8-bit alu for the 3xkk, 4xkk, 5xy0 and 9xy0 compares and the 7xkk and 8xyn arithmetic
// depends on c8x_pkg
`timescale 1ns / 1ps
module c8x_alu (
  input  c8x_pkg::alu_req_t req,
  output c8x_pkg::alu_rsp_t rsp
);
  logic [8:0] sum;
  logic [8:0] dif;
  assign sum = {1'b0, req.a} + {1'b0, req.b};
  assign dif = {1'b0, req.a} - {1'b0, req.b};
  always_comb begin
    rsp.eq = (req.a == req.b);
    rsp.flag = 1'b0;
    rsp.y = req.b;
    unique case (req.op)
      c8x_pkg::ALU_PASS_B: rsp.y = req.b;
      c8x_pkg::ALU_OR:  rsp.y = req.a | req.b;
      c8x_pkg::ALU_AND: rsp.y = req.a & req.b;
      c8x_pkg::ALU_XOR: rsp.y = req.a ^ req.b;
      c8x_pkg::ALU_ADD: begin rsp.y = sum[7:0]; rsp.flag = sum[8]; end
      c8x_pkg::ALU_SUB: begin rsp.y = dif[7:0]; rsp.flag = ~dif[8]; end
      c8x_pkg::ALU_SHR: begin rsp.y = {1'b0, req.a[7:1]}; rsp.flag = req.a[0]; end
      c8x_pkg::ALU_SHL: begin rsp.y = {req.a[6:0], 1'b0}; rsp.flag = req.a[7]; end
      default: rsp.y = req.b;
    endcase
  end
endmodule

// File: design/chip8_instruction_execute_unit.sv
// chip-8 execute unit top level: sequencer, register file, stack, memory
// depends on c8x_pkg, c8x_alu, c8x_ram
// path from input transfer to result transfer: host writes and simple opcodes go S_EXEC then S_OUT,
// host reads and 00ee also wait on a registered memory or stack read, fx33 and fx55 walk memory
// in S_MEM (fx55 stores one register per cycle) and fx65 alternates S_MEM and S_RDW per register
// one item at a time: the next input transfer can come in the cycle after the result transfer
// reset (synchronous, rst_n low) clears registers, index, stack pointer and timers
// memory and return stack contents are undefined until written
`timescale 1ns / 1ps
module chip8_instruction_execute_unit #(
  parameter int MEM_DEPTH   = 4096,
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [15:0] in_opcode,
  input  logic [11:0] in_pc_in,
  input  logic [7:0]  in_random_byte,
  input  logic [15:0] in_key_mask,
  input  logic [11:0] in_host_addr,
  input  logic [7:0]  in_host_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_action,
  output logic [11:0] out_next_pc,
  output logic [2:0]  out_display_op,
  output logic [7:0]  out_disp_x,
  output logic [7:0]  out_disp_y,
  output logic [3:0]  out_disp_rows,
  output logic [11:0] out_sprite_addr,
  output logic [7:0]  out_read_data
);
  localparam int AW = $clog2(MEM_DEPTH);
  localparam int SW = $clog2(STACK_DEPTH);
  localparam int PW = $clog2(STACK_DEPTH + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;  // decode and alu step
  localparam logic [2:0] S_MEM  = 3'd2;  // memory walk (bcd, block store/load)
  localparam logic [2:0] S_RDW  = 3'd3;  // wait on registered memory read
  localparam logic [2:0] S_OUT  = 3'd4;  // result held for transfer
  localparam logic [2:0] S_STK  = 3'd5;  // wait on return stack read

  logic [2:0]  state_r, state_nxt;
  logic [7:0]  vregs_r [16];
  logic [11:0] index_r;
  logic [PW-1:0] sp_r;
  logic [7:0]  delay_r, sound_r;

  // latched request
  logic [1:0]  req_r;
  logic [15:0] op_r;
  logic [11:0] pc_r;
  logic [7:0]  rnd_r;
  logic [15:0] keys_r;
  logic [11:0] haddr_r;
  logic [7:0]  hdata_r;
  logic [4:0]  k_r;  // walk counter

  // result registers
  logic [2:0]  act_r;
  logic [11:0] npc_r;
  logic [2:0]  dop_r;
  logic [7:0]  dx_r, dy_r;
  logic [3:0]  drows_r;
  logic [11:0] saddr_r;
  logic [7:0]  rdata_r;

  logic [3:0] x, y, n;
  logic [7:0] kk, vx, vy;
  assign x  = op_r[11:8];
  assign y  = op_r[7:4];
  assign n  = op_r[3:0];
  assign kk = op_r[7:0];
  assign vx = vregs_r[x];
  assign vy = vregs_r[y];

  // bcd digits from small constant-divide logic
  logic [7:0] bcd_h, bcd_t, bcd_o;
  logic [7:0] rem100;
  always_comb begin
    bcd_h = (vx >= 8'd200) ? 8'd2 : ((vx >= 8'd100) ? 8'd1 : 8'd0);
    rem100 = vx - 8'(bcd_h * 8'd100);
    bcd_t = 8'((16'(rem100) * 16'd205) >> 11);
    bcd_o = rem100 - 8'(bcd_t * 8'd10);
  end

  // shared alu
  c8x_pkg::alu_req_t alu_req;
  c8x_pkg::alu_rsp_t alu_rsp;
  c8x_alu u_alu (.req(alu_req), .rsp(alu_rsp));

  always_comb begin
    alu_req.a = vx;
    alu_req.b = vy;
    alu_req.op = c8x_pkg::ALU_PASS_B;
    unique case (op_r[15:12])
      4'h3, 4'h4: alu_req.b = kk;
      4'h7: begin alu_req.b = kk; alu_req.op = c8x_pkg::ALU_ADD; end
      4'h8: begin
        unique case (n)
          4'h1: alu_req.op = c8x_pkg::ALU_OR;
          4'h2: alu_req.op = c8x_pkg::ALU_AND;
          4'h3: alu_req.op = c8x_pkg::ALU_XOR;
          4'h4: alu_req.op = c8x_pkg::ALU_ADD;
          4'h5: alu_req.op = c8x_pkg::ALU_SUB;
          4'h6: alu_req.op = c8x_pkg::ALU_SHR;
          4'h7: begin
            alu_req.a = vy; alu_req.b = vx; alu_req.op = c8x_pkg::ALU_SUB;
          end
          4'hE: alu_req.op = c8x_pkg::ALU_SHL;
          default: alu_req.op = c8x_pkg::ALU_PASS_B;
        endcase
      end
      default: alu_req.op = c8x_pkg::ALU_PASS_B;
    endcase
  end

  // byte memory
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata, mem_rdata;
  c8x_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_mem (
    .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(mem_wdata), .rdata(mem_rdata)
  );

  // return stack
  logic          stk_we;
  logic [SW-1:0] stk_addr;
  logic [11:0]   stk_rdata;
  c8x_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stk (
    .clk(clk), .we(stk_we), .addr(stk_addr), .wdata(pc_r), .rdata(stk_rdata)
  );

  logic stack_empty, stack_full;
  assign stack_empty = (sp_r == '0);
  assign stack_full  = (sp_r >= PW'(STACK_DEPTH));

  // one spare bit so i + k carries past 4095 into larger memories
  logic [12:0] walk_addr;
  assign walk_addr = {1'b0, index_r} + 13'(k_r);
  logic last_walk;
  assign last_walk = (op_r[7:0] == 8'h33) ? (k_r == 5'd2) : (k_r[3:0] == x);

  always_comb begin
    mem_we = 1'b0;
    mem_addr = AW'(walk_addr);
    mem_wdata = vregs_r[k_r[3:0]];
    if (state_r == S_EXEC && req_r != c8x_pkg::REQ_EXEC) begin
      mem_addr = AW'(haddr_r);
      mem_wdata = hdata_r;
      mem_we = (req_r == c8x_pkg::REQ_WRITE);
    end else if (state_r == S_MEM && op_r[7:0] != 8'h65) begin
      mem_we = 1'b1;
      if (op_r[7:0] == 8'h33) begin
        mem_wdata = (k_r == 5'd0) ? bcd_h : ((k_r == 5'd1) ? bcd_t : bcd_o);
      end
    end
  end

  assign stk_we   = (state_r == S_EXEC) && (req_r == c8x_pkg::REQ_EXEC) &&
                    (op_r[15:12] == 4'h2) && !stack_full;
  assign stk_addr = stk_we ? SW'(sp_r) : SW'(sp_r - PW'(1));

  // host read data arrives in the cycle after exec; capture it on first S_OUT cycle
  logic rd_pending;
  assign rd_pending = (req_r == c8x_pkg::REQ_READ) && (k_r == 5'd0);

  assign in_stall  = (state_r != S_IDLE);
  // result is offered only once the read byte is in place
  assign out_valid = (state_r == S_OUT) && !rd_pending;
  assign out_action = act_r;
  assign out_next_pc = npc_r;
  assign out_display_op = dop_r;
  assign out_disp_x = dx_r;
  assign out_disp_y = dy_r;
  assign out_disp_rows = drows_r;
  assign out_sprite_addr = saddr_r;
  assign out_read_data = rdata_r;

  logic key_hit;
  assign key_hit = keys_r[vx[3:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      for (int i = 0; i < 16; i++) vregs_r[i] <= 8'd0;
      index_r <= '0;
      sp_r <= '0;
      delay_r <= '0;
      sound_r <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_IDLE: if (in_valid) begin
          req_r <= in_req_type; op_r <= in_opcode; pc_r <= in_pc_in;
          rnd_r <= in_random_byte; keys_r <= in_key_mask;
          haddr_r <= in_host_addr; hdata_r <= in_host_data;
          k_r <= '0;
        end
        S_EXEC: begin
          act_r <= c8x_pkg::ACT_INC; npc_r <= pc_r; dop_r <= c8x_pkg::DISP_NONE;
          dx_r <= '0; dy_r <= '0; drows_r <= '0; saddr_r <= '0; rdata_r <= '0;
          if (req_r != c8x_pkg::REQ_EXEC) begin
            npc_r <= '0;
          end else begin
            if (sound_r != 8'd0) sound_r <= sound_r - 8'd1;
            unique case (op_r[15:12])
              4'h0: begin
                if (op_r[15:4] == 12'h00C) begin
                  dop_r <= c8x_pkg::DISP_SDOWN; drows_r <= n;
                end else if (op_r == 16'h00E0) dop_r <= c8x_pkg::DISP_CLEAR;
                else if (op_r == 16'h00EE) begin
                  if (stack_empty || sp_r > PW'(STACK_DEPTH)) act_r <= c8x_pkg::ACT_ERR;
                  else sp_r <= sp_r - PW'(1);
                end
                else if (op_r == 16'h00FB) dop_r <= c8x_pkg::DISP_SRIGHT;
                else if (op_r == 16'h00FC) dop_r <= c8x_pkg::DISP_SLEFT;
                else if (op_r == 16'h00FD) act_r <= c8x_pkg::ACT_QUIT;
                else if (op_r == 16'h00FF) act_r <= c8x_pkg::ACT_ERR;
              end
              4'h1: begin npc_r <= op_r[11:0]; act_r <= c8x_pkg::ACT_NOINC; end
              4'h2: begin
                if (stack_full) act_r <= c8x_pkg::ACT_ERR;
                else begin
                  sp_r <= sp_r + PW'(1); npc_r <= op_r[11:0];
                  act_r <= c8x_pkg::ACT_NOINC;
                end
              end
              4'h3: if (alu_rsp.eq) act_r <= c8x_pkg::ACT_SKIP;
              4'h4: if (!alu_rsp.eq) act_r <= c8x_pkg::ACT_SKIP;
              4'h5: if (alu_rsp.eq) act_r <= c8x_pkg::ACT_SKIP;
              4'h6: vregs_r[x] <= kk;
              4'h7: vregs_r[x] <= alu_rsp.y;
              4'h8: begin
                if (n <= 4'h7 || n == 4'hE) begin
                  if (n >= 4'h4) vregs_r[15] <= {7'd0, alu_rsp.flag};
                  vregs_r[x] <= alu_rsp.y;
                end else act_r <= c8x_pkg::ACT_ERR;
              end
              4'h9: if (!alu_rsp.eq) act_r <= c8x_pkg::ACT_SKIP;
              4'hA: index_r <= op_r[11:0];
              4'hB: begin
                npc_r <= op_r[11:0] + {4'd0, vregs_r[0]};
                act_r <= c8x_pkg::ACT_NOINC;
              end
              4'hC: vregs_r[x] <= rnd_r & kk;
              4'hD: begin
                dop_r <= c8x_pkg::DISP_DRAW; dx_r <= vx; dy_r <= vy;
                drows_r <= n; saddr_r <= index_r;
              end
              4'hE: begin
                if (kk == 8'h9E) begin
                  if (key_hit) act_r <= c8x_pkg::ACT_SKIP;
                end else if (kk == 8'hA1) begin
                  if (!key_hit) act_r <= c8x_pkg::ACT_SKIP;
                end else act_r <= c8x_pkg::ACT_ERR;
              end
              default: begin
                unique case (kk)
                  8'h07: vregs_r[x] <= delay_r;
                  8'h0A: ;
                  8'h15: delay_r <= vx;
                  8'h18: sound_r <= vx;
                  8'h1E: index_r <= index_r + {4'd0, vx};
                  8'h29: index_r <= 12'({4'd0, vx} * 12'd5);
                  8'h33, 8'h55, 8'h65: ;
                  default: act_r <= c8x_pkg::ACT_ERR;
                endcase
              end
            endcase
          end
        end
        S_MEM: if (op_r[7:0] != 8'h65) k_r <= k_r + 5'd1;
        S_RDW: begin
          vregs_r[k_r[3:0]] <= mem_rdata;
          k_r <= k_r + 5'd1;
        end
        S_STK: npc_r <= stk_rdata;
        S_OUT: if (req_r == c8x_pkg::REQ_READ && k_r == 5'd0) begin
          rdata_r <= mem_rdata;
          k_r <= 5'd1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_EXEC;
      S_EXEC: begin
        if (req_r == c8x_pkg::REQ_EXEC && op_r[15:12] == 4'hF &&
            (kk == 8'h33 || kk == 8'h55 || kk == 8'h65)) state_nxt = S_MEM;
        else if (req_r == c8x_pkg::REQ_EXEC && op_r == 16'h00EE && !stack_empty &&
                 sp_r <= PW'(STACK_DEPTH)) state_nxt = S_STK;
        else state_nxt = S_OUT;
      end
      S_MEM: begin
        if (op_r[7:0] == 8'h65) state_nxt = S_RDW;
        else if (last_walk) state_nxt = S_OUT;
      end
      S_RDW: state_nxt = last_walk ? S_OUT : S_MEM;
      S_STK: state_nxt = S_OUT;
      S_OUT: if (!rd_pending && !out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // stack pointer never exceeds the stack depth
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= PW'(STACK_DEPTH)) else $error("stack pointer out of range");
  // no transfer is taken while a result is pending
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input open while result pending");
  // a finished result stays offered until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall && !rd_pending) |=> out_valid && $stable(out_action))
    else $error("result dropped while stalled");
endmodule

// File: verif/testbench.sv
// testbench for chip8_instruction_execute_unit: directed and random opcodes and host accesses
// checks every result against an in-file machine model; depends on c8x_pkg and the design
`timescale 1ns / 1ps
module testbench;
  localparam int MEM_SIZE = 4096;
  localparam int STK_SIZE = 16;
  localparam int IDLE_LIMIT = 5000;

  typedef struct {
    logic [1:0]  req;
    logic [15:0] op;
    logic [11:0] pc;
    logic [7:0]  rnd;
    logic [15:0] keys;
    logic [11:0] haddr;
    logic [7:0]  hdata;
  } chip_req_t;

  typedef struct {
    logic [2:0]  action;
    logic [11:0] npc;
    logic [2:0]  dop;
    logic [7:0]  dx;
    logic [7:0]  dy;
    logic [3:0]  rows;
    logic [11:0] saddr;
    logic [7:0]  rdata;
  } chip_rsp_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_req_type;
  logic [15:0] in_opcode;
  logic [11:0] in_pc_in;
  logic [7:0]  in_random_byte;
  logic [15:0] in_key_mask;
  logic [11:0] in_host_addr;
  logic [7:0]  in_host_data;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_action;
  logic [11:0] out_next_pc;
  logic [2:0]  out_display_op;
  logic [7:0]  out_disp_x;
  logic [7:0]  out_disp_y;
  logic [3:0]  out_disp_rows;
  logic [11:0] out_sprite_addr;
  logic [7:0]  out_read_data;

  // machine state mirrored by the checker
  logic [7:0]  m_v [16];
  logic [11:0] m_i;
  logic [11:0] m_stk [STK_SIZE];
  int          m_sp;
  logic [7:0]  m_delay;
  logic [7:0]  m_sound;
  logic [7:0]  m_mem [MEM_SIZE];
  logic        m_wr [MEM_SIZE];  // byte has been written

  chip_rsp_t pending_q[$];
  chip_rsp_t got_rsp;
  int        n_errors;
  int        idle_pct;
  int        stall_pct;
  int        hold_len;
  int        quiet_cycles;

  chip8_instruction_execute_unit u_top (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // one cpu step: update mirrored state and return the expected result
  task automatic run_machine(input chip_req_t q, output chip_rsp_t r);
    logic [3:0]  x;
    logic [3:0]  y;
    logic [3:0]  n;
    logic [7:0]  kk;
    logic [11:0] nnn;
    logic [7:0]  vx;
    logic [7:0]  vy;
    logic [8:0]  sum;
    r = '{c8x_pkg::ACT_INC, q.pc, c8x_pkg::DISP_NONE, 8'd0, 8'd0, 4'd0, 12'd0, 8'd0};
    x = q.op[11:8];
    y = q.op[7:4];
    n = q.op[3:0];
    kk = q.op[7:0];
    nnn = q.op[11:0];
    vx = m_v[x];
    vy = m_v[y];
    if (q.req != c8x_pkg::REQ_EXEC) begin
      r.npc = 12'd0;
      if (q.req == c8x_pkg::REQ_WRITE) begin
        m_mem[q.haddr] = q.hdata;
        m_wr[q.haddr] = 1'b1;
      end else if (q.req == c8x_pkg::REQ_READ) r.rdata = m_mem[q.haddr];
      return;
    end
    if (m_sound != 8'd0) m_sound = m_sound - 8'd1;
    case (q.op[15:12])
      4'h0: begin
        if (q.op[15:4] == 12'h00C) begin
          r.dop = c8x_pkg::DISP_SDOWN;
          r.rows = n;
        end else if (q.op == 16'h00E0) r.dop = c8x_pkg::DISP_CLEAR;
        else if (q.op == 16'h00EE) begin
          if (m_sp == 0) r.action = c8x_pkg::ACT_ERR;
          else begin
            m_sp--;
            r.npc = m_stk[m_sp];
          end
        end else if (q.op == 16'h00FB) r.dop = c8x_pkg::DISP_SRIGHT;
        else if (q.op == 16'h00FC) r.dop = c8x_pkg::DISP_SLEFT;
        else if (q.op == 16'h00FD) r.action = c8x_pkg::ACT_QUIT;
        else if (q.op == 16'h00FF) r.action = c8x_pkg::ACT_ERR;
      end
      4'h1: begin
        r.npc = nnn;
        r.action = c8x_pkg::ACT_NOINC;
      end
      4'h2: begin
        if (m_sp >= STK_SIZE) r.action = c8x_pkg::ACT_ERR;
        else begin
          m_stk[m_sp] = q.pc;
          m_sp++;
          r.npc = nnn;
          r.action = c8x_pkg::ACT_NOINC;
        end
      end
      4'h3: if (vx == kk) r.action = c8x_pkg::ACT_SKIP;
      4'h4: if (vx != kk) r.action = c8x_pkg::ACT_SKIP;
      4'h5: if (vx == vy) r.action = c8x_pkg::ACT_SKIP;
      4'h6: m_v[x] = kk;
      4'h7: m_v[x] = vx + kk;
      4'h8: begin
        // flag goes first so that vx wins when x is f
        case (n)
          4'h0: m_v[x] = vy;
          4'h1: m_v[x] = vx | vy;
          4'h2: m_v[x] = vx & vy;
          4'h3: m_v[x] = vx ^ vy;
          4'h4: begin
            sum = {1'b0, vx} + {1'b0, vy};
            m_v[15] = {7'd0, sum[8]};
            m_v[x] = sum[7:0];
          end
          4'h5: begin
            m_v[15] = {7'd0, vx >= vy};
            m_v[x] = vx - vy;
          end
          4'h6: begin
            m_v[15] = {7'd0, vx[0]};
            m_v[x] = vx >> 1;
          end
          4'h7: begin
            m_v[15] = {7'd0, vy >= vx};
            m_v[x] = vy - vx;
          end
          4'hE: begin
            m_v[15] = {7'd0, vx[7]};
            m_v[x] = vx << 1;
          end
          default: r.action = c8x_pkg::ACT_ERR;
        endcase
      end
      4'h9: if (vx != vy) r.action = c8x_pkg::ACT_SKIP;
      4'hA: m_i = nnn;
      4'hB: begin
        r.npc = nnn + {4'd0, m_v[0]};
        r.action = c8x_pkg::ACT_NOINC;
      end
      4'hC: m_v[x] = q.rnd & kk;
      4'hD: begin
        r.dop = c8x_pkg::DISP_DRAW;
        r.dx = vx;
        r.dy = vy;
        r.rows = n;
        r.saddr = m_i;
      end
      4'hE: begin
        if (kk == 8'h9E) begin
          if (q.keys[vx[3:0]]) r.action = c8x_pkg::ACT_SKIP;
        end else if (kk == 8'hA1) begin
          if (!q.keys[vx[3:0]]) r.action = c8x_pkg::ACT_SKIP;
        end else r.action = c8x_pkg::ACT_ERR;
      end
      default: begin
        case (kk)
          8'h07: m_v[x] = m_delay;
          8'h0A: ;
          8'h15: m_delay = vx;
          8'h18: m_sound = vx;
          8'h1E: m_i = m_i + {4'd0, vx};
          8'h29: m_i = 12'(vx * 5);
          8'h33: begin
            m_mem[m_i] = 8'(vx / 100);
            m_mem[12'(m_i + 1)] = 8'((vx / 10) % 10);
            m_mem[12'(m_i + 2)] = 8'(vx % 10);
            for (int k = 0; k < 3; k++) m_wr[12'(m_i + k)] = 1'b1;
          end
          8'h55: begin
            for (int k = 0; k <= x; k++) begin
              m_mem[12'(m_i + k)] = m_v[k];
              m_wr[12'(m_i + k)] = 1'b1;
            end
          end
          8'h65: for (int k = 0; k <= x; k++) m_v[k] = m_mem[12'(m_i + k)];
          default: r.action = c8x_pkg::ACT_ERR;
        endcase
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  // true when every byte a block load of v0..vx would read holds data
  function automatic logic block_written(input logic [3:0] x);
    for (int k = 0; k <= x; k++) begin
      if (!m_wr[12'(m_i + k)]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // offer one item, with random idle cycles before it, and wait for its transfer
  task automatic send_item(input chip_req_t q);
    chip_rsp_t r;
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= q.req;
    in_opcode <= q.op;
    in_pc_in <= q.pc;
    in_random_byte <= q.rnd;
    in_key_mask <= q.keys;
    in_host_addr <= q.haddr;
    in_host_data <= q.hdata;
    do @(posedge clk); while (in_stall);
    run_machine(q, r);
    pending_q.push_back(r);
  endtask

  task automatic send_op(input logic [15:0] op);
    chip_req_t q;
    logic [15:0] use_op;
    use_op = op;
    // a block load only reads written bytes, so store the block instead
    if (use_op[15:12] == 4'hF && use_op[7:0] == 8'h65 && !block_written(use_op[11:8]))
      use_op[7:0] = 8'h55;
    q = '{c8x_pkg::REQ_EXEC, use_op, 12'($urandom), 8'($urandom), 16'($urandom),
          12'($urandom), 8'($urandom)};
    send_item(q);
  endtask

  task automatic send_host(input logic [1:0] req, input logic [11:0] a, input logic [7:0] d);
    chip_req_t q;
    q = '{req, 16'($urandom), 12'($urandom), 8'($urandom), 16'($urandom), a, d};
    send_item(q);
  endtask

  task automatic wait_drained();
    while (pending_q.size() > 0) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_opcode();
    logic [15:0] op;
    op = 16'($urandom);
    case (op[15:12])
      4'h0: begin
        case ($urandom_range(0, 9))
          0: op = 16'h00E0;
          1, 2: op = 16'h00EE;
          3: op = {12'h00C, op[3:0]};
          4: op = 16'h00FB;
          5: op = 16'h00FC;
          6: op = 16'h00FD;
          7: op = 16'h00FE;
          8: op = 16'h00FF;
          default: ;
        endcase
      end
      4'hE: if ($urandom_range(0, 5) != 0) op[7:0] = $urandom_range(0, 1) ? 8'h9E : 8'hA1;
      4'hF: begin
        // mostly defined fx codes, some undefined ones
        case ($urandom_range(0, 10))
          0: op[7:0] = 8'h07;
          1: op[7:0] = 8'h0A;
          2: op[7:0] = 8'h15;
          3: op[7:0] = 8'h18;
          4: op[7:0] = 8'h1E;
          5: op[7:0] = 8'h29;
          6: op[7:0] = 8'h33;
          7: op[7:0] = 8'h55;
          8: op[7:0] = 8'h65;
          default: ;
        endcase
      end
      default: ;
    endcase
    return op;
  endfunction

  // seed bytes 000-02f and fff, then read back 000 and fff; reads only ever go to written bytes
  task automatic test_mem_fill();
    for (int a = 0; a < 48; a++) send_host(c8x_pkg::REQ_WRITE, 12'(a), 8'($urandom));
    send_host(c8x_pkg::REQ_WRITE, 12'hFFF, 8'($urandom));
    send_host(c8x_pkg::REQ_READ, 12'h000, 8'h00);
    send_host(c8x_pkg::REQ_READ, 12'hFFF, 8'hFF);
  endtask

  task automatic test_directed();
    logic [15:0] ops [$];
    ops = '{16'h00EE, 16'h00E0, 16'h00C0, 16'h00CF, 16'h00FB, 16'h00FC, 16'h00FD,
            16'h00FE, 16'h00FF, 16'h0123, 16'h6AFF, 16'h6B01, 16'h8AB4, 16'h6AFF,
            16'h8AB5, 16'h8BA7, 16'h8AB6, 16'h8ABE, 16'h8FA4, 16'h8AB8, 16'h8ABF,
            16'h2FFE, 16'h00EE, 16'h3AFF, 16'h4A00, 16'h5AB0, 16'h9ABF, 16'hAFFE,
            16'h60FF, 16'hBFFF, 16'hC3FF, 16'hDABF, 16'hEA9E, 16'hEAA1, 16'hEAFF,
            16'hFA15, 16'hF207, 16'hFA18, 16'hFA1E, 16'hFA29, 16'hFA33, 16'hFF55,
            16'hFF65, 16'hF130, 16'hF175};
    foreach (ops[k]) send_op(ops[k]);
  endtask

  // push until the return stack is full, overflow once, then unwind past empty
  task automatic test_stack_limits();
    for (int k = 0; k <= STK_SIZE; k++) send_op({4'h2, 12'($urandom)});
    for (int k = 0; k <= STK_SIZE; k++) send_op(16'h00EE);
  endtask

  task automatic test_random(input int count, input int idle, input int stall);
    logic [11:0] addr;
    logic [1:0]  req;
    idle_pct = idle;
    stall_pct = stall;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 7) == 0) begin
        addr = 12'($urandom);
        req = $urandom_range(0, 1) ? c8x_pkg::REQ_WRITE : c8x_pkg::REQ_READ;
        if (!m_wr[addr]) req = c8x_pkg::REQ_WRITE;
        send_host(req, addr, 8'($urandom));
      end else send_op(rand_opcode());
    end
  endtask

  // receiver holds off for a long stretch while items keep coming
  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    hold_len = 300;
    for (int k = 0; k < 20; k++) send_op(rand_opcode());
    in_valid <= 1'b0;
    wait_drained();
    // sender pauses until every result is back
    for (int k = 0; k < 10; k++) send_op(rand_opcode());
    in_valid <= 1'b0;
    wait_drained();
  endtask

  // receiver stall, with an optional long hold-off counted here
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_len > 0) begin
      out_stall <= 1'b1;
      hold_len = hold_len - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // result checker: each transfer against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        got_rsp = pending_q.pop_front();
        if (out_action !== got_rsp.action)
          report_mismatch("action", out_action, got_rsp.action);
        if (out_next_pc !== got_rsp.npc)
          report_mismatch("next_pc", out_next_pc, got_rsp.npc);
        if (out_display_op !== got_rsp.dop)
          report_mismatch("display_op", out_display_op, got_rsp.dop);
        if (out_disp_x !== got_rsp.dx) report_mismatch("disp_x", out_disp_x, got_rsp.dx);
        if (out_disp_y !== got_rsp.dy) report_mismatch("disp_y", out_disp_y, got_rsp.dy);
        if (out_disp_rows !== got_rsp.rows)
          report_mismatch("disp_rows", out_disp_rows, got_rsp.rows);
        if (out_sprite_addr !== got_rsp.saddr)
          report_mismatch("sprite_addr", out_sprite_addr, got_rsp.saddr);
        if (out_read_data !== got_rsp.rdata)
          report_mismatch("read_data", out_read_data, got_rsp.rdata);
      end
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("chip8_instruction_execute_unit test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    n_errors = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_len = 0;
    quiet_cycles = 0;
    for (int k = 0; k < 16; k++) m_v[k] = 8'd0;
    for (int k = 0; k < MEM_SIZE; k++) m_wr[k] = 1'b0;
    m_i = 12'd0;
    m_sp = 0;
    m_delay = 8'd0;
    m_sound = 8'd0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_req_type <= c8x_pkg::REQ_EXEC;
    in_opcode <= 16'd0;
    in_pc_in <= 12'd0;
    in_random_byte <= 8'd0;
    in_key_mask <= 16'd0;
    in_host_addr <= 12'd0;
    in_host_data <= 8'd0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_mem_fill();
    test_directed();
    test_stack_limits();
    test_random(160, 0, 0);
    test_random(140, 59, 0);
    test_random(140, 0, 59);
    test_random(140, 17, 17);
    test_backpressure();
    test_random(30, 0, 0);

    in_valid <= 1'b0;
    wait_drained();
    repeat (50) @(posedge clk);
    if (n_errors == 0) begin
      $display("chip8_instruction_execute_unit test passed");
    end else begin
      $display("chip8_instruction_execute_unit test failed");
    end
    $finish;
  end
endmodule

// File: sim.f
design/c8x_pkg.sv
design/c8x_ram.sv
design/c8x_alu.sv
design/chip8_instruction_execute_unit.sv
verif/testbench.sv
